[sv/lrucd_pkg.sv]
// Package for the LRU write-back cache directory: request codes and field widths.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package lrucd_pkg;

   localparam int BLOCK_W = 32;   // disk block number width
   localparam int SLOT_W  = 4;    // width of the reported slot field
   localparam int AGE_W   = 32;   // access counter and age stamp width

   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_FLUSH = 2'd2,
      REQ_CLEAR = 2'd3
   } req_code_type;

endpackage

`default_nettype wire

[sv/lrucd_req_if.sv]
// Request channel of the cache directory: valid/ready handshake plus request fields.
// Depends on lrucd_pkg.
`default_nettype none

interface lrucd_req_if;
   import lrucd_pkg::*;

   logic                 valid;
   logic                 ready;
   req_code_type         req_type;
   logic [BLOCK_W-1:0]   block_number;

   modport source (output valid, req_type, block_number, input ready);
   modport sink   (input valid, req_type, block_number, output ready);
endinterface

`default_nettype wire

[sv/lrucd_rsp_if.sv]
// Result channel of the cache directory: valid/ready handshake plus result fields.
// Depends on lrucd_pkg.
`default_nettype none

interface lrucd_rsp_if;
   import lrucd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [SLOT_W-1:0]    slot;
   logic                 writeback_needed;
   logic [BLOCK_W-1:0]   writeback_block;
   logic                 fill_needed;
   logic                 last;

   modport source (output valid, hit, slot, writeback_needed, writeback_block,
                   fill_needed, last, input ready);
   modport sink   (input valid, hit, slot, writeback_needed, writeback_block,
                   fill_needed, last, output ready);
endinterface

`default_nettype wire

[sv/lru_writeback_block_cache_directory.sv]
// Top level of the fully associative LRU write-back cache directory.
// Depends on lrucd_pkg, lrucd_req_if and lrucd_rsp_if.
`default_nettype none

// Directory of a SLOTS-way fully associative write-back block cache. Each request
// transfer is a read, write, flush or clear; results leave on the rsp channel, one
// per read, write or clear and one per dirty slot on a flush, or a single empty one
// for a flush with nothing dirty (last marks the end). Tags and age stamps live in a
// single-port-read RAM that a small sequencer sweeps one slot per cycle, feeding one
// shared tag compare and one age compare. A read or write sweeps every slot, then
// updates the chosen slot, loads the result and returns to idle; a clear and a flush
// with nothing dirty load their result at once; a flush sweeps up to the last dirty
// slot and reports each dirty slot in turn. A waiting result
// sits in an output register, so the block returns to idle and takes the next
// request while the result has not been taken; only a further result waits for it
// to drain.
// Clear drops the valid and dirty bits and the counter at once: no clearing pass.

module lru_writeback_block_cache_directory #(
   parameter int SLOTS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   lrucd_req_if.sink    req_chan,
   lrucd_rsp_if.source  rsp_chan
);
   import lrucd_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_FL_SCAN,
      ST_FL_EMIT,
      ST_EMIT
   } state_type;

   // sequencer and directory control state
   state_type            state_ff, state_in;
   req_code_type         op_ff, op_in;
   logic [BLOCK_W-1:0]   blk_ff, blk_in;
   logic [CNT_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic                 inv_ff, inv_in;
   logic [IDX_W-1:0]     inv_idx_ff, inv_idx_in;
   logic                 best_first_ff, best_first_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [AGE_W-1:0]     best_age_ff, best_age_in;
   logic [BLOCK_W-1:0]   best_tag_ff, best_tag_in;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [SLOTS-1:0]     dirty_ff, dirty_in;
   logic [AGE_W-1:0]     counter_ff, counter_in;
   logic                 flush_cont_ff, flush_cont_in;

   // staged result, waiting for the output register
   logic                 res_hit_ff, res_hit_in;
   logic [SLOT_W-1:0]    res_slot_ff, res_slot_in;
   logic                 res_wb_ff, res_wb_in;
   logic [BLOCK_W-1:0]   res_wbblk_ff, res_wbblk_in;
   logic                 res_fill_ff, res_fill_in;
   logic                 res_last_ff, res_last_in;

   // output register
   logic                 out_valid_ff, out_valid_in;
   logic                 out_hit_ff, out_hit_in;
   logic [SLOT_W-1:0]    out_slot_ff, out_slot_in;
   logic                 out_wb_ff, out_wb_in;
   logic [BLOCK_W-1:0]   out_wbblk_ff, out_wbblk_in;
   logic                 out_fill_ff, out_fill_in;
   logic                 out_last_ff, out_last_in;

   // tag / age RAM
   logic [BLOCK_W-1:0]   tag_mem [SLOTS];
   logic [AGE_W-1:0]     age_mem [SLOTS];
   logic [BLOCK_W-1:0]   tag_rd_ff;
   logic [AGE_W-1:0]     age_rd_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 mem_we;
   logic [IDX_W-1:0]     sel_idx;
   logic [AGE_W-1:0]     cnt_next;

   logic [SLOTS-1:0]     vd;        // valid and dirty
   logic [SLOTS-1:0]     vd_above;  // valid and dirty above the slot being flushed
   logic                 out_free;

   assign vd       = valid_ff & dirty_ff;
   assign cnt_next = counter_ff + AGE_W'(1);
   assign out_free = !out_valid_ff || rsp_chan.ready;

   // hit wins, then the first empty slot, then the oldest stamp
   assign sel_idx = hit_ff ? hit_idx_ff : (inv_ff ? inv_idx_ff : best_idx_ff);

   always_comb begin
      for (int j = 0; j < SLOTS; j++) begin
         vd_above[j] = vd[j] && (j > int'(cmp_idx_ff));
      end
   end

   assign req_chan.ready            = (state_ff == ST_IDLE);
   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.hit              = out_hit_ff;
   assign rsp_chan.slot             = out_slot_ff;
   assign rsp_chan.writeback_needed = out_wb_ff;
   assign rsp_chan.writeback_block  = out_wbblk_ff;
   assign rsp_chan.fill_needed      = out_fill_ff;
   assign rsp_chan.last             = out_last_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      blk_in        = blk_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      inv_in        = inv_ff;
      inv_idx_in    = inv_idx_ff;
      best_first_in = best_first_ff;
      best_idx_in   = best_idx_ff;
      best_age_in   = best_age_ff;
      best_tag_in   = best_tag_ff;
      valid_in      = valid_ff;
      dirty_in      = dirty_ff;
      counter_in    = counter_ff;
      flush_cont_in = flush_cont_ff;
      res_hit_in    = res_hit_ff;
      res_slot_in   = res_slot_ff;
      res_wb_in     = res_wb_ff;
      res_wbblk_in  = res_wbblk_ff;
      res_fill_in   = res_fill_ff;
      res_last_in   = res_last_ff;
      out_valid_in  = out_valid_ff;
      out_hit_in    = out_hit_ff;
      out_slot_in   = out_slot_ff;
      out_wb_in     = out_wb_ff;
      out_wbblk_in  = out_wbblk_ff;
      out_fill_in   = out_fill_ff;
      out_last_in   = out_last_ff;
      rd_addr       = scan_idx_ff[IDX_W-1:0];
      mem_we        = 1'b0;

      // drop the result once the sink takes it
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in       = req_chan.req_type;
               blk_in      = req_chan.block_number;
               scan_idx_in = '0;
               // stage the empty result used by clear and by a clean flush
               res_hit_in    = 1'b0;
               res_slot_in   = '0;
               res_wb_in     = 1'b0;
               res_wbblk_in  = '0;
               res_fill_in   = 1'b0;
               res_last_in   = 1'b1;
               flush_cont_in = 1'b0;
               case (req_chan.req_type)
                  REQ_READ, REQ_WRITE: begin
                     hit_in        = 1'b0;
                     inv_in        = 1'b0;
                     best_first_in = 1'b1;
                     state_in      = ST_SCAN;
                  end
                  REQ_FLUSH: begin
                     state_in = (vd == '0) ? ST_EMIT : ST_FL_SCAN;
                  end
                  REQ_CLEAR: begin
                     valid_in   = '0;
                     dirty_in   = '0;
                     counter_in = '0;
                     state_in   = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // issue one RAM read per cycle
            if (scan_idx_ff != CNT_W'(SLOTS)) begin
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = scan_idx_ff[IDX_W-1:0];
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end
            // compare the slot read in the previous cycle
            if (cmp_vld_ff) begin
               if (valid_ff[cmp_idx_ff]) begin
                  if (!hit_ff && (tag_rd_ff == blk_ff)) begin
                     hit_in     = 1'b1;
                     hit_idx_in = cmp_idx_ff;
                  end
                  if (best_first_ff || (age_rd_ff < best_age_ff)) begin
                     best_first_in = 1'b0;
                     best_idx_in   = cmp_idx_ff;
                     best_age_in   = age_rd_ff;
                     best_tag_in   = tag_rd_ff;
                  end
               end else if (!inv_ff) begin
                  inv_in     = 1'b1;
                  inv_idx_in = cmp_idx_ff;
               end
               if (scan_idx_ff == CNT_W'(SLOTS)) begin
                  state_in = ST_UPDATE;
               end
            end
         end

         ST_UPDATE: begin
            mem_we            = 1'b1;
            counter_in        = cnt_next;
            valid_in[sel_idx] = 1'b1;
            if (op_ff == REQ_WRITE) begin
               dirty_in[sel_idx] = 1'b1;
            end else if (!hit_ff) begin
               dirty_in[sel_idx] = 1'b0;
            end
            res_hit_in   = hit_ff;
            res_slot_in  = SLOT_W'(sel_idx);
            // only an LRU victim can be valid, so only it can need a write-back
            res_wb_in    = !hit_ff && !inv_ff && dirty_ff[best_idx_ff];
            res_wbblk_in = (!hit_ff && !inv_ff && dirty_ff[best_idx_ff]) ? best_tag_ff
                                                                          : '0;
            res_fill_in  = !hit_ff && (op_ff == REQ_READ);
            res_last_in  = 1'b1;
            state_in     = ST_EMIT;
         end

         ST_FL_SCAN: begin
            rd_addr     = scan_idx_ff[IDX_W-1:0];
            cmp_idx_in  = scan_idx_ff[IDX_W-1:0];
            scan_idx_in = scan_idx_ff + CNT_W'(1);
            if (vd[scan_idx_ff[IDX_W-1:0]]) begin
               state_in = ST_FL_EMIT;
            end
         end

         ST_FL_EMIT: begin
            dirty_in[cmp_idx_ff] = 1'b0;
            res_hit_in    = 1'b0;
            res_slot_in   = SLOT_W'(cmp_idx_ff);
            res_wb_in     = 1'b1;
            res_wbblk_in  = tag_rd_ff;
            res_fill_in   = 1'b0;
            res_last_in   = (vd_above == '0);
            flush_cont_in = (vd_above != '0);
            state_in      = ST_EMIT;
         end

         ST_EMIT: begin
            // hold until the output register is free
            if (out_free) begin
               out_valid_in = 1'b1;
               out_hit_in   = res_hit_ff;
               out_slot_in  = res_slot_ff;
               out_wb_in    = res_wb_ff;
               out_wbblk_in = res_wbblk_ff;
               out_fill_in  = res_fill_ff;
               out_last_in  = res_last_ff;
               state_in     = flush_cont_ff ? ST_FL_SCAN : ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      blk_ff       <= blk_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_idx_ff   <= hit_idx_in;
      inv_idx_ff   <= inv_idx_in;
      best_idx_ff  <= best_idx_in;
      best_age_ff  <= best_age_in;
      best_tag_ff  <= best_tag_in;
      res_hit_ff   <= res_hit_in;
      res_slot_ff  <= res_slot_in;
      res_wb_ff    <= res_wb_in;
      res_wbblk_ff <= res_wbblk_in;
      res_fill_ff  <= res_fill_in;
      res_last_ff  <= res_last_in;
      out_hit_ff   <= out_hit_in;
      out_slot_ff  <= out_slot_in;
      out_wb_ff    <= out_wb_in;
      out_wbblk_ff <= out_wbblk_in;
      out_fill_ff  <= out_fill_in;
      out_last_ff  <= out_last_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_idx_ff   <= '0;
         cmp_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         inv_ff        <= 1'b0;
         best_first_ff <= 1'b1;
         valid_ff      <= '0;
         dirty_ff      <= '0;
         counter_ff    <= '0;
         flush_cont_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_idx_ff   <= scan_idx_in;
         cmp_vld_ff    <= cmp_vld_in;
         hit_ff        <= hit_in;
         inv_ff        <= inv_in;
         best_first_ff <= best_first_in;
         valid_ff      <= valid_in;
         dirty_ff      <= dirty_in;
         counter_ff    <= counter_in;
         flush_cont_ff <= flush_cont_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // tag and age RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[sel_idx] <= blk_ff;
         age_mem[sel_idx] <= cnt_next;
      end
      tag_rd_ff <= tag_mem[rd_addr];
      age_rd_ff <= age_mem[rd_addr];
   end

`ifndef SYNTHESIS
   a_dirty_implies_valid: assert property (@(posedge clock) disable iff (reset)
      (dirty_ff & ~valid_ff) == '0)
      else $error("dirty bit set on an invalid slot");

   a_hit_no_wb_no_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.hit) |-> (!rsp_chan.writeback_needed &&
                                            !rsp_chan.fill_needed))
      else $error("hit reported together with write-back or fill");

   a_wbblk_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.writeback_needed) |-> (rsp_chan.writeback_block == '0))
      else $error("write-back block nonzero without write-back");

   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == ST_SCAN))
      else $error("compare pipeline active outside the lookup sweep");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
// Testbench for the LRU write-back cache directory: directed and random requests
// against a shadow directory that predicts every result. Depends on lrucd_pkg,
// lrucd_req_if, lrucd_rsp_if and lru_writeback_block_cache_directory.
`default_nettype none

module testbench;
   import lrucd_pkg::*;

   localparam int DIR_SLOTS    = 16;
   localparam int RANDOM_ITEMS = 480;
   localparam int CALM_FROM    = 400;      // no idling from this random item on
   localparam int DRAIN_CYCLES = 80;       // longest flush sweep plus margin
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOT_COUNT    = 24;       // a few more blocks than slots

   typedef struct packed {
      logic                hit;
      logic [SLOT_W-1:0]   slot;
      logic                writeback_needed;
      logic [BLOCK_W-1:0]  writeback_block;
      logic                fill_needed;
      logic                last;
   } dir_result_type;

   // Shadow copy of the directory: predicts the results of each accepted
   // request and matches the block's results against them in order.
   class directory_shadow_type;
      logic [BLOCK_W-1:0] tags [DIR_SLOTS];
      bit                 valid [DIR_SLOTS];
      bit                 dirty [DIR_SLOTS];
      logic [AGE_W-1:0]   ages [DIR_SLOTS];
      logic [AGE_W-1:0]   access_count;
      dir_result_type     pending_results [$];
      int                 mismatches;

      function new();
         wipe();
         mismatches = 0;
      endfunction

      function void wipe();
         for (int i = 0; i < DIR_SLOTS; i++) begin
            tags[i]  = '0;
            valid[i] = 1'b0;
            dirty[i] = 1'b0;
            ages[i]  = '0;
         end
         access_count = '0;
      endfunction

      function void accept_request(req_code_type op, logic [BLOCK_W-1:0] blk);
         dir_result_type r;
         int             s;
         bit             found;
         int             flushed;
         r = '0;
         if (op == REQ_READ || op == REQ_WRITE) begin
            access_count = access_count + 1'b1;
            found = 1'b0;
            s = -1;
            for (int i = 0; i < DIR_SLOTS; i++)
               if (!found && valid[i] && tags[i] == blk) begin
                  found = 1'b1;
                  s = i;
               end
            if (!found)
               for (int i = 0; i < DIR_SLOTS; i++)
                  if (s < 0 && !valid[i]) s = i;
            if (s < 0) begin
               // all valid: oldest stamp, lowest index on a tie
               s = 0;
               for (int i = 1; i < DIR_SLOTS; i++)
                  if (ages[i] < ages[s]) s = i;
            end
            r.hit  = found;
            r.slot = SLOT_W'(s);
            if (!found) begin
               if (valid[s] && dirty[s]) begin
                  r.writeback_needed = 1'b1;
                  r.writeback_block  = tags[s];
               end
               tags[s]  = blk;
               valid[s] = 1'b1;
               dirty[s] = 1'b0;
               r.fill_needed = (op == REQ_READ);
            end
            if (op == REQ_WRITE) dirty[s] = 1'b1;
            ages[s] = access_count;
            r.last  = 1'b1;
            pending_results.push_back(r);
         end else if (op == REQ_FLUSH) begin
            flushed = 0;
            for (int i = 0; i < DIR_SLOTS; i++)
               if (valid[i] && dirty[i]) begin
                  r = '0;
                  r.slot             = SLOT_W'(i);
                  r.writeback_needed = 1'b1;
                  r.writeback_block  = tags[i];
                  dirty[i] = 1'b0;
                  pending_results.push_back(r);
                  flushed++;
               end
            if (flushed == 0) begin
               r = '0;
               r.last = 1'b1;
               pending_results.push_back(r);
            end else begin
               pending_results[pending_results.size() - 1].last = 1'b1;
            end
         end else begin
            wipe();
            r.last = 1'b1;
            pending_results.push_back(r);
         end
      endfunction

      function void check_result(dir_result_type got);
         dir_result_type want;
         if (pending_results.size() == 0) begin
            $error("unexpected result: slot %0d last %0b", got.slot, got.last);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         if (got.hit !== want.hit) begin
            $error("hit: expected %0h, actual %0h", want.hit, got.hit);
            mismatches++;
         end
         if (got.slot !== want.slot) begin
            $error("slot: expected %0h, actual %0h", want.slot, got.slot);
            mismatches++;
         end
         if (got.writeback_needed !== want.writeback_needed) begin
            $error("writeback_needed: expected %0h, actual %0h",
                   want.writeback_needed, got.writeback_needed);
            mismatches++;
         end
         if (got.writeback_block !== want.writeback_block) begin
            $error("writeback_block: expected %0h, actual %0h",
                   want.writeback_block, got.writeback_block);
            mismatches++;
         end
         if (got.fill_needed !== want.fill_needed) begin
            $error("fill_needed: expected %0h, actual %0h",
                   want.fill_needed, got.fill_needed);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0h, actual %0h", want.last, got.last);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   req_code_type         req_op = REQ_READ;
   logic [BLOCK_W-1:0]   req_block = '0;
   logic                 rsp_take = 1'b0;
   bit                   calm = 1'b0;
   int                   stall_left = 0;
   int                   cycles = 0;
   logic [BLOCK_W-1:0]   hot_blocks [HOT_COUNT];
   directory_shadow_type shadow;

   lrucd_req_if req_chan ();
   lrucd_rsp_if rsp_chan ();

   assign req_chan.valid        = req_valid;
   assign req_chan.req_type     = req_op;
   assign req_chan.block_number = req_block;
   assign rsp_chan.ready        = rsp_take;

   lru_writeback_block_cache_directory #(.SLOTS(DIR_SLOTS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result side: check every transfer, then pick ready for the next edge.
   // Ready is dropped in bursts of random length that stop once the run is calm.
   always @(posedge clock) begin
      if (reset) begin
         rsp_take   <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            shadow.check_result('{rsp_chan.hit, rsp_chan.slot, rsp_chan.writeback_needed,
                                  rsp_chan.writeback_block, rsp_chan.fill_needed,
                                  rsp_chan.last});
         if (stall_left > 0) begin
            rsp_take   <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_take   <= 1'b0;
            stall_left <= $urandom_range(1, 7) - 1;
         end else begin
            rsp_take <= 1'b1;
         end
      end
   end

   // Present one request and hold it until the transfer edge. Valid stays
   // high into the next request unless an idle burst is drawn.
   task automatic send_request(req_code_type op, logic [BLOCK_W-1:0] blk);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_block <= blk;
      do @(posedge clock); while (!req_chan.ready);
      shadow.accept_request(op, blk);
   endtask

   // Draw a block: mostly from a small hot set so hits and evictions mix,
   // sometimes a fresh 32-bit value.
   function automatic logic [BLOCK_W-1:0] pick_block();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return hot_blocks[$urandom_range(0, HOT_COUNT - 1)];
   endfunction

   initial begin
      int roll;
      shadow = new();
      for (int i = 0; i < HOT_COUNT; i++) hot_blocks[i] = $urandom;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty flush, block number extremes, hits on read and write,
      // fill every slot, then evict two dirty victims by age.
      send_request(REQ_FLUSH, 32'h0);
      send_request(REQ_READ,  32'h0000_0000);
      send_request(REQ_WRITE, 32'hFFFF_FFFF);
      send_request(REQ_READ,  32'h0000_0000);
      send_request(REQ_WRITE, 32'h0000_0000);
      for (int i = 0; i < DIR_SLOTS - 2; i++)
         send_request(REQ_READ, (i % 2) ? 32'hAAAA_AA00 + i : 32'h5555_5500 + i);
      send_request(REQ_READ,  32'h1234_5678);   // oldest is the dirty all-ones block
      send_request(REQ_WRITE, 32'h8765_4321);   // next oldest is dirty block zero
      send_request(REQ_FLUSH, 32'hFFFF_FFFF);   // dirty slots drain in slot order
      send_request(REQ_FLUSH, 32'h0);           // nothing left dirty
      send_request(REQ_CLEAR, 32'hFFFF_FFFF);
      send_request(REQ_READ,  32'h1234_5678);   // miss again after the clear

      // Random: mostly reads and writes over the hot set, with flushes mixed
      // in and rare clears so the directory fills and evicts.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == CALM_FROM) calm = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 45)
            send_request(REQ_READ, pick_block());
         else if (roll < 90)
            send_request(REQ_WRITE, pick_block());
         else if (roll < 98)
            send_request(REQ_FLUSH, $urandom);
         else begin
            send_request(REQ_CLEAR, $urandom);
            hot_blocks[$urandom_range(0, HOT_COUNT - 1)] = $urandom;
         end
      end
      req_valid <= 1'b0;

      // Drain, then give the block time to show any stray result.
      while (shadow.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.outstanding() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
